// File: hdl/uv_sphere_vertex_generator_macros.svh
// ----------------------------------------------------------------------------
// UV sphere vertex generator assertion macros
// Shared assertion forms for the checker of the vertex generator.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UVS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uvs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uvs assertion failed");

`endif

// File: hdl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Word types, register indexes and CORDIC constants shared by the block.
// ----------------------------------------------------------------------------
package uvs_pkg;

    typedef struct packed {
        logic [7:0] ring_index;
        logic [7:0] sector_index;
    } t_in_word;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [31:0]        color_rgba;
        logic [15:0]        quad_first_index;
        logic               quad_valid;
    } t_out_word;

    localparam int CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_COUNT   = 8'd0,
        CFG_SECTOR_COUNT = 8'd1,
        CFG_RADIUS       = 8'd2,
        CFG_COLOR        = 8'd3
    } t_cfg_index;

    localparam logic [8:0]  RST_RING_COUNT   = 9'd16;
    localparam logic [8:0]  RST_SECTOR_COUNT = 9'd16;
    localparam logic [15:0] RST_RADIUS       = 16'd256;
    localparam logic [31:0] RST_COLOR        = 32'd0;

    localparam logic [31:0] COLOR_RED_MASK   = 32'h00FF0000;
    localparam logic [31:0] COLOR_GRN_MASK   = 32'h0000FF00;
    localparam logic [31:0] COLOR_BLU_MASK   = 32'h000000FF;
    localparam logic [31:0] COLOR_ALP_MASK   = 32'hFF000000;

    // CORDIC datapath: Q2.30 coordinates, angles in 2^-32 turns.
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
    } t_rot;

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] res;
        if (v > 34'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -34'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

// File: hdl/uvs_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per register stage, NW stages deep.
// ----------------------------------------------------------------------------
module uvs_div_pipe #(
    parameter int NW = 25,
    parameter int DW = 9
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];
    logic [DW-1:0] r_den [NW];

    logic [DW-1:0] n_rem [NW];
    logic [NW-1:0] n_num [NW];
    logic [NW-1:0] n_quo [NW];
    logic [DW-1:0] n_den [NW];

    always_comb begin
        logic [DW:0]   cand;
        logic [DW-1:0] rem_p;
        logic [NW-1:0] num_p;
        logic [NW-1:0] quo_p;
        logic [DW-1:0] den_p;
        for (int k = 0; k < NW; k++) begin
            if (k == 0) begin
                rem_p = '0;
                num_p = i_num;
                quo_p = '0;
                den_p = i_den;
            end else begin
                rem_p = r_rem[(k == 0) ? 0 : k-1];
                num_p = r_num[(k == 0) ? 0 : k-1];
                quo_p = r_quo[(k == 0) ? 0 : k-1];
                den_p = r_den[(k == 0) ? 0 : k-1];
            end
            cand = {rem_p, num_p[NW-1-k]};
            if (cand >= {1'b0, den_p}) begin
                n_rem[k] = DW'(cand - {1'b0, den_p});
                n_quo[k] = {quo_p[NW-2:0], 1'b1};
            end else begin
                n_rem[k] = cand[DW-1:0];
                n_quo[k] = {quo_p[NW-2:0], 1'b0};
            end
            n_num[k] = num_p;
            n_den[k] = den_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= n_den[k];
            end
        end
    end

    assign o_quo = r_quo[NW-1];

endmodule

// File: hdl/uvs_cordic_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC
// Rotation-mode CORDIC giving cosine and sine in Q2.30, one step per stage.
// ----------------------------------------------------------------------------
module uvs_cordic_pipe
    import uvs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_angle,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    t_rot r_rot  [CORDIC_STEPS];
    logic r_flip [CORDIC_STEPS];
    t_rot n_rot  [CORDIC_STEPS];
    logic signed [31:0] r_cos;
    logic signed [31:0] r_sin;

    function automatic t_rot rot_step(input t_rot a, input int i);
        t_rot b;
        if (!a.z[CORDIC_W-1]) begin
            b.x = a.x - (a.y >>> i);
            b.y = a.y + (a.x >>> i);
            b.z = a.z - ATAN_TURNS[i];
        end else begin
            b.x = a.x + (a.y >>> i);
            b.y = a.y - (a.x >>> i);
            b.z = a.z + ATAN_TURNS[i];
        end
        return b;
    endfunction

    // Angles in the second and third quadrant are turned by half a turn,
    // and the result is negated at the end.
    logic        w_flip;
    logic [31:0] w_ang;
    t_rot        w_init;

    assign w_flip   = i_angle[31] ^ i_angle[30];
    assign w_ang    = {i_angle[30], i_angle[30:0]};
    assign w_init.x = CORDIC_GAIN;
    assign w_init.y = '0;
    assign w_init.z = {{(CORDIC_W-32){w_ang[31]}}, w_ang};

    always_comb begin
        n_rot[0] = rot_step(w_init, 0);
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            n_rot[i] = rot_step(r_rot[i-1], i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flip[0] <= w_flip;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_rot[i] <= n_rot[i];
            end
            for (int i = 1; i < CORDIC_STEPS; i++) begin
                r_flip[i] <= r_flip[i-1];
            end
            if (r_flip[CORDIC_STEPS-1]) begin
                r_cos <= 32'(-r_rot[CORDIC_STEPS-1].x);
                r_sin <= 32'(-r_rot[CORDIC_STEPS-1].y);
            end else begin
                r_cos <= r_rot[CORDIC_STEPS-1].x[31:0];
                r_sin <= r_rot[CORDIC_STEPS-1].y[31:0];
            end
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// File: hdl/uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Position, normal, texture coordinates, color and quad index of one grid
// point of a UV sphere, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_stall     i_in  (t_in_word)
//  out       output     o_out_valid / i_out_stall   o_out (t_out_word)
//  cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  One word enters per cycle while o_in_stall is low; the pipe is built from
//  the bit-per-stage dividers and the 24-step CORDIC.
//  Synchronous active-low reset restores the cfg registers and empties the pipe.
//  The whole pipe advances together; a skid word behind the output register
//  absorbs one stall, and o_in_stall is high while that word is held and
//  falls once it moves into the output register.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int MAX_RINGS   = 256,
    parameter int MAX_SECTORS = 256,
    parameter int ANGLE_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int MAXC = (MAX_RINGS > MAX_SECTORS) ? MAX_RINGS : MAX_SECTORS;
    localparam int DWC  = $clog2(MAXC) + 1;
    localparam int DW   = (DWC > 9) ? DWC : 9;
    localparam int KW   = (DW > 9) ? DW : 9;
    localparam int TW   = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
    localparam int NW   = TW + 9;
    localparam int CL   = CORDIC_STEPS + 1;
    localparam int LAT  = NW + CL + 3;
    localparam int TL   = CL + 3;

    typedef struct packed {
        logic [31:0] rgba;
        logic [15:0] qidx;
        logic        qv;
    } t_side;

    // Configuration registers.
    logic [8:0]  r_ring_count;
    logic [8:0]  r_sector_count;
    logic [15:0] r_radius;
    logic [31:0] r_color;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_count   <= RST_RING_COUNT;
            r_sector_count <= RST_SECTOR_COUNT;
            r_radius       <= RST_RADIUS;
            r_color        <= RST_COLOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RING_COUNT:   r_ring_count   <= i_cfg_data[8:0];
                CFG_SECTOR_COUNT: r_sector_count <= i_cfg_data[8:0];
                CFG_RADIUS:       r_radius       <= i_cfg_data[15:0];
                CFG_COLOR:        r_color        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [DW-1:0] clamp_count(input logic [8:0] c, input int maxc);
        logic [KW-1:0] ce;
        ce = KW'(c);
        if (ce < KW'(2)) begin
            ce = KW'(2);
        end else if (ce > KW'(maxc)) begin
            ce = KW'(maxc);
        end
        return DW'(ce);
    endfunction

    // Pipe control.
    logic r_skid_v;
    logic w_en;

    assign w_en       = !r_skid_v;
    assign o_in_stall = r_skid_v;

    // Input stage: counts, numerators and the side fields.
    logic [DW-1:0] w_rings;
    logic [DW-1:0] w_sectors;
    logic [DW-1:0] w_rm1;
    logic [DW-1:0] w_sm1;
    t_side         w_side;

    assign w_rings   = clamp_count(r_ring_count, MAX_RINGS);
    assign w_sectors = clamp_count(r_sector_count, MAX_SECTORS);
    assign w_rm1     = w_rings - DW'(1);
    assign w_sm1     = w_sectors - DW'(1);

    assign w_side.rgba = {8'((r_color & COLOR_RED_MASK) >> 16),
                          8'((r_color & COLOR_GRN_MASK) >> 8),
                          8'(r_color & COLOR_BLU_MASK),
                          8'((r_color & COLOR_ALP_MASK) >> 24)};
    assign w_side.qidx = 16'(16'(i_in.ring_index) * 16'(w_sectors))
                         + 16'(i_in.sector_index);
    assign w_side.qv   = (DW'(i_in.ring_index) < w_rm1) && (DW'(i_in.sector_index) < w_sm1);

    logic [NW-1:0] r_num_ta, r_num_pa, r_num_u, r_num_v;
    logic [DW-1:0] r_den_ta, r_den_s, r_den_r;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num_ta <= (NW'(i_in.ring_index) << ANGLE_BITS) + NW'(w_rm1);
            r_num_pa <= (NW'(i_in.sector_index) << ANGLE_BITS) + NW'(w_sm1 >> 1);
            r_num_u  <= (NW'(i_in.sector_index) << 16) + NW'(w_sm1 >> 1);
            r_num_v  <= (NW'(i_in.ring_index) << 16) + NW'(w_rm1 >> 1);
            r_den_ta <= DW'({w_rm1, 1'b0});
            r_den_s  <= w_sm1;
            r_den_r  <= w_rm1;
        end
    end

    // Valid bits and side fields travel alongside the datapath.
    logic  r_vld  [LAT+1];
    t_side r_side [LAT+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i <= LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side;
            for (int i = 1; i <= LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Dividers for the two angles and the two texture coordinates.
    logic [NW-1:0] w_quo_ta, w_quo_pa, w_quo_u, w_quo_v;

    uvs_div_pipe #(.NW(NW), .DW(DW)) u_div_ta (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_num_ta), .i_den(r_den_ta), .o_quo(w_quo_ta)
    );
    uvs_div_pipe #(.NW(NW), .DW(DW)) u_div_pa (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_num_pa), .i_den(r_den_s), .o_quo(w_quo_pa)
    );
    uvs_div_pipe #(.NW(NW), .DW(DW)) u_div_u (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_num_u), .i_den(r_den_s), .o_quo(w_quo_u)
    );
    uvs_div_pipe #(.NW(NW), .DW(DW)) u_div_v (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_num_v), .i_den(r_den_r), .o_quo(w_quo_v)
    );

    logic [15:0] w_tex_u, w_tex_v;
    logic [31:0] r_tex [TL];

    assign w_tex_u = (|w_quo_u[NW-1:16]) ? 16'hFFFF : w_quo_u[15:0];
    assign w_tex_v = (|w_quo_v[NW-1:16]) ? 16'hFFFF : w_quo_v[15:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tex[0] <= {w_tex_u, w_tex_v};
            for (int i = 1; i < TL; i++) begin
                r_tex[i] <= r_tex[i-1];
            end
        end
    end

    // Sine and cosine of theta and phi; angles wrap modulo a turn.
    logic [31:0]        w_ang_t, w_ang_p;
    logic signed [31:0] w_ct, w_st, w_cp, w_sp;

    assign w_ang_t = 32'(w_quo_ta[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    assign w_ang_p = 32'(w_quo_pa[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);

    uvs_cordic_pipe u_cordic_t (
        .i_clk(i_clk), .i_en(w_en), .i_angle(w_ang_t), .o_cos(w_ct), .o_sin(w_st)
    );
    uvs_cordic_pipe u_cordic_p (
        .i_clk(i_clk), .i_en(w_en), .i_angle(w_ang_p), .o_cos(w_cp), .o_sin(w_sp)
    );

    // Normal and position stages.
    logic signed [63:0] r_m1_p0, r_m1_p2;
    logic signed [15:0] r_m1_n1;
    logic signed [15:0] r_m2_n [3];
    logic signed [15:0] r_m3_n [3];
    logic signed [23:0] r_m3_pos [3];
    logic signed [33:0] w_ny;
    logic signed [33:0] w_pr [3];

    assign w_ny = (-34'(w_ct) + 34'sd16384) >>> 15;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_pr[k] = 34'(r_m2_n[k]) * $signed({18'd0, r_radius});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_p0   <= 64'(w_cp) * 64'(w_st);
            r_m1_p2   <= 64'(w_sp) * 64'(w_st);
            r_m1_n1   <= sat16(w_ny);
            r_m2_n[0] <= sat16(34'((r_m1_p0 + (64'sd1 <<< 44)) >>> 45));
            r_m2_n[1] <= r_m1_n1;
            r_m2_n[2] <= sat16(34'((r_m1_p2 + (64'sd1 <<< 44)) >>> 45));
            for (int k = 0; k < 3; k++) begin
                r_m3_n[k]   <= r_m2_n[k];
                r_m3_pos[k] <= 24'((w_pr[k] + 34'sd256) >>> 9);
            end
        end
    end

    t_out_word w_pipe_word;

    assign w_pipe_word.pos_x            = r_m3_pos[0];
    assign w_pipe_word.pos_y            = r_m3_pos[1];
    assign w_pipe_word.pos_z            = r_m3_pos[2];
    assign w_pipe_word.norm_x           = r_m3_n[0];
    assign w_pipe_word.norm_y           = r_m3_n[1];
    assign w_pipe_word.norm_z           = r_m3_n[2];
    assign w_pipe_word.tex_u            = r_tex[TL-1][31:16];
    assign w_pipe_word.tex_v            = r_tex[TL-1][15:0];
    assign w_pipe_word.color_rgba       = r_side[LAT].rgba;
    assign w_pipe_word.quad_first_index = r_side[LAT].qidx;
    assign w_pipe_word.quad_valid       = r_side[LAT].qv;

    // Output register with one skid word behind it.
    logic      r_out_v;
    t_out_word r_out;
    t_out_word r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_out_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r_vld[LAT];
            end
        end else if (r_vld[LAT] && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_out_stall) begin
            r_out <= r_skid_v ? r_skid : w_pipe_word;
        end else if (r_vld[LAT] && !r_skid_v) begin
            r_skid <= w_pipe_word;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

// File: hdl/uvs_checker.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator checker
// Port-level assertions on the vertex generator, attached by bind.
// ----------------------------------------------------------------------------
`include "uv_sphere_vertex_generator_macros.svh"

module uvs_checker
    import uvs_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input t_in_word             i_in,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_word            o_out,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [31:0]          i_cfg_data
);

    // A held output word stays valid and unchanged.
    `UVS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

    // The input side only stalls while a word waits in the output register.
    `UVS_ASSERT_NOW(a_stall_needs_out, i_clk, i_rst_n, o_in_stall, o_out_valid)

    // A quad exists only away from the last ring and sector, so neither
    // texture coordinate can have saturated.
    `UVS_ASSERT_NOW(a_quad_tex, i_clk, i_rst_n, o_out_valid && o_out.quad_valid, (o_out.tex_u != 16'hFFFF) && (o_out.tex_v != 16'hFFFF))

    // The first ring is the south pole, where the normal points straight down.
    `UVS_ASSERT_NOW(a_pole_normal, i_clk, i_rst_n, o_out_valid && (o_out.tex_v == 16'd0), o_out.norm_y == 16'sh8000)

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (.*);

// File: tb/uv_sphere_vertex_generator_tb.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Drives grid points through the in channel under random stalls, predicts
// every output word with a local fixed-point model of the sphere math and
// compares the words in order. Register settings change between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module uv_sphere_vertex_generator_tb;
    import uvs_pkg::*;

    localparam int LATENCY  = 54;
    localparam int MAX_CNT  = 256;
    localparam int ABITS    = 16;
    localparam longint GAIN = 652032874;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    uv_sphere_vertex_generator u_dut (.*);

    always #1 i_clk = ~i_clk;

    longint atan_tab [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // Shadow copy of the registers.
    logic [8:0]  ring_reg = RST_RING_COUNT;
    logic [8:0]  sector_reg = RST_SECTOR_COUNT;
    logic [15:0] radius_reg = RST_RADIUS;
    logic [31:0] color_reg = RST_COLOR;

    t_in_word  pending_points [$];
    t_out_word expected_vertices [$];
    int        error_count = 0;
    bit        no_idle = 1'b0;
    bit        hold_out = 1'b0;
    int        in_gap = 0;
    int        out_gap = 0;

    // Stall as sampled at the last rising edge, for the driver's bookkeeping.
    logic o_in_stall_q = 1'b0;

    function automatic longint floor_shift(longint v, int k);
        return (v < 0) ? -((-(v + 1)) >>> k) - 1 : v >>> k;
    endfunction

    function automatic longint clamp_cnt(longint c);
        return (c < 2) ? 2 : ((c > MAX_CNT) ? MAX_CNT : c);
    endfunction

    // Angle in 2^-32 turns to cosine and sine in Q2.30.
    function automatic void rotate(input logic [31:0] ang, output longint cs,
                                   output longint sn);
        bit     flip;
        longint x, y, z, dx, dy;
        flip = (ang[31:30] == 2'd1 || ang[31:30] == 2'd2);
        if (flip) begin
            ang = ang + 32'h8000_0000;
        end
        x = GAIN;
        y = 0;
        z = ang[31] ? longint'(ang) - 64'h1_0000_0000 : longint'(ang);
        for (int i = 0; i < 24; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic longint clip16(longint v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic logic [15:0] tex_of(longint n, longint d);
        longint t;
        t = ((n << 16) + d / 2) / d;
        return (t > 65535) ? 16'hFFFF : t[15:0];
    endfunction

    function automatic t_out_word vertex_of(t_in_word w);
        t_out_word o;
        longint r, s, rings, sectors, ta, pa, ct, st, cp, sp, p;
        longint nrm [3];
        r = longint'(w.ring_index);
        s = longint'(w.sector_index);
        rings = clamp_cnt(longint'(ring_reg));
        sectors = clamp_cnt(longint'(sector_reg));
        ta = (((r << ABITS) + (rings - 1)) / (2 * (rings - 1))) & 16'hFFFF;
        pa = (((s << ABITS) + (sectors - 1) / 2) / (sectors - 1)) & 16'hFFFF;
        rotate(32'(ta << 16), ct, st);
        rotate(32'(pa << 16), cp, sp);
        nrm[0] = clip16(floor_shift(cp * st + (64'sd1 << 44), 45));
        nrm[1] = clip16(floor_shift(-ct + (64'sd1 << 14), 15));
        nrm[2] = clip16(floor_shift(sp * st + (64'sd1 << 44), 45));
        p = floor_shift(nrm[0] * longint'(radius_reg) + 256, 9);
        o.pos_x = p[23:0];
        p = floor_shift(nrm[1] * longint'(radius_reg) + 256, 9);
        o.pos_y = p[23:0];
        p = floor_shift(nrm[2] * longint'(radius_reg) + 256, 9);
        o.pos_z = p[23:0];
        o.norm_x = nrm[0][15:0];
        o.norm_y = nrm[1][15:0];
        o.norm_z = nrm[2][15:0];
        o.tex_u = tex_of(s, sectors - 1);
        o.tex_v = tex_of(r, rings - 1);
        o.color_rgba = {color_reg[23:16], color_reg[15:8], color_reg[7:0], color_reg[31:24]};
        p = r * sectors + s;
        o.quad_first_index = p[15:0];
        o.quad_valid = (r < rings - 1) && (s < sectors - 1);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    // Driver: offers queued points and drives output stalls, with random idle bursts.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall_q) begin
                pending_points.pop_front();
            end
            if (i_in_valid && o_in_stall_q) begin
                // Hold the word until it is taken.
            end else if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 15) == 0) begin
                in_gap <= $urandom_range(0, 12);
                i_in_valid <= 1'b0;
            end else if (pending_points.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in <= pending_points[0];
            end else begin
                i_in_valid <= 1'b0;
            end
            if (hold_out) begin
                i_out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_stall <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 15) == 0) begin
                out_gap <= $urandom_range(0, 12);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Monitor: predicts on acceptance, checks each output word.
    always @(posedge i_clk) begin
        t_out_word want;
        o_in_stall_q <= o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_vertices = {expected_vertices, vertex_of(i_in)};
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_vertices.size() == 0) begin
                    report_mismatch("unexpected word",
                                    longint'(o_out.quad_first_index), 0);
                end else begin
                    want = expected_vertices.pop_front();
                    if (o_out.pos_x !== want.pos_x)
                        report_mismatch("pos_x", longint'(o_out.pos_x),
                                        longint'(want.pos_x));
                    if (o_out.pos_y !== want.pos_y)
                        report_mismatch("pos_y", longint'(o_out.pos_y),
                                        longint'(want.pos_y));
                    if (o_out.pos_z !== want.pos_z)
                        report_mismatch("pos_z", longint'(o_out.pos_z),
                                        longint'(want.pos_z));
                    if (o_out.norm_x !== want.norm_x)
                        report_mismatch("norm_x", longint'(o_out.norm_x),
                                        longint'(want.norm_x));
                    if (o_out.norm_y !== want.norm_y)
                        report_mismatch("norm_y", longint'(o_out.norm_y),
                                        longint'(want.norm_y));
                    if (o_out.norm_z !== want.norm_z)
                        report_mismatch("norm_z", longint'(o_out.norm_z),
                                        longint'(want.norm_z));
                    if (o_out.tex_u !== want.tex_u)
                        report_mismatch("tex_u", longint'(o_out.tex_u),
                                        longint'(want.tex_u));
                    if (o_out.tex_v !== want.tex_v)
                        report_mismatch("tex_v", longint'(o_out.tex_v),
                                        longint'(want.tex_v));
                    if (o_out.color_rgba !== want.color_rgba)
                        report_mismatch("color_rgba", longint'(o_out.color_rgba),
                                        longint'(want.color_rgba));
                    if (o_out.quad_first_index !== want.quad_first_index)
                        report_mismatch("quad_first_index",
                                        longint'(o_out.quad_first_index),
                                        longint'(want.quad_first_index));
                    if (o_out.quad_valid !== want.quad_valid)
                        report_mismatch("quad_valid", longint'(o_out.quad_valid),
                                        longint'(want.quad_valid));
                end
            end
        end
    end

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RING_COUNT:   ring_reg = data[8:0];
            CFG_SECTOR_COUNT: sector_reg = data[8:0];
            CFG_RADIUS:       radius_reg = data[15:0];
            CFG_COLOR:        color_reg = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_points.size() == 0 && !i_in_valid);
        wait (expected_vertices.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic add_point(input int r, input int s);
        t_in_word w;
        w.ring_index = 8'(r);
        w.sector_index = 8'(s);
        pending_points = {pending_points, w};
    endtask

    // Mostly in-range grid points, some out of range.
    task automatic add_random(input int n);
        int rc, sc;
        rc = int'(clamp_cnt(longint'(ring_reg)));
        sc = int'(clamp_cnt(longint'(sector_reg)));
        repeat (n) begin
            if ($urandom_range(0, 9) < 8) begin
                add_point($urandom_range(0, rc - 1), $urandom_range(0, sc - 1));
            end else begin
                add_point($urandom_range(0, 255), $urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, poles, seams, field extremes, out of range.
        add_point(0, 0);
        add_point(15, 15);
        add_point(14, 14);
        add_point(7, 4);
        add_point(16, 16);
        add_point(255, 255);
        add_point(0, 255);
        add_point(255, 0);
        add_point(8'hAA, 8'h55);
        add_point(8'h55, 8'hAA);
        drain();

        write_reg(CFG_RING_COUNT, 32'd2);
        write_reg(CFG_SECTOR_COUNT, 32'd2);
        write_reg(CFG_RADIUS, 32'hFFFF);
        write_reg(CFG_COLOR, 32'h1234_5678);
        add_point(0, 0);
        add_point(1, 1);
        add_point(2, 3);
        drain();

        // Counts below two and above the maximum get clamped.
        write_reg(CFG_RING_COUNT, 32'd0);
        write_reg(CFG_SECTOR_COUNT, 32'h1FF);
        write_reg(CFG_RADIUS, 32'd0);
        write_reg(CFG_COLOR, 32'hFFFF_FFFF);
        add_point(1, 255);
        add_point(0, 128);
        drain();

        write_reg(CFG_RING_COUNT, 32'd256);
        write_reg(CFG_SECTOR_COUNT, 32'd256);
        write_reg(CFG_RADIUS, 32'd1);
        add_point(255, 255);
        add_point(254, 254);
        add_point(128, 64);
        add_random(250);
        drain();

        // The sender pauses until every expected word has come.
        write_reg(CFG_RING_COUNT, 32'd1);
        write_reg(CFG_SECTOR_COUNT, 32'd300);
        write_reg(CFG_RADIUS, 32'd256);
        write_reg(CFG_COLOR, 32'hA5C3_0F96);
        add_random(250);
        drain();

        write_reg(CFG_RING_COUNT, $urandom_range(2, 64));
        write_reg(CFG_SECTOR_COUNT, $urandom_range(2, 64));
        write_reg(CFG_RADIUS, $urandom);
        write_reg(CFG_COLOR, $urandom);
        // Long receiver hold-off while the sender keeps offering.
        hold_out = 1'b1;
        add_random(300);
        repeat (200) @(posedge i_clk);
        hold_out = 1'b0;
        drain();

        write_reg(CFG_RING_COUNT, $urandom_range(2, 256));
        write_reg(CFG_SECTOR_COUNT, $urandom_range(2, 256));
        write_reg(CFG_RADIUS, $urandom);
        write_reg(CFG_COLOR, $urandom);
        add_random(350);
        drain();

        no_idle = 1'b1;
        write_reg(CFG_RING_COUNT, 32'd17);
        write_reg(CFG_SECTOR_COUNT, 32'd33);
        write_reg(CFG_RADIUS, 32'h0180);
        add_random(300);
        drain();

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/uvs_pkg.sv
hdl/uvs_div_pipe.sv
hdl/uvs_cordic_pipe.sv
hdl/uv_sphere_vertex_generator.sv
hdl/uvs_checker.sv
tb/uv_sphere_vertex_generator_tb.sv
